// ===== design/quadratic_probe_hash_table_core_macros.svh =====
// assertion macros used by the hash table controller
`ifndef QUADRATIC_PROBE_HASH_TABLE_CORE_MACROS_SVH
`define QUADRATIC_PROBE_HASH_TABLE_CORE_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define QPHT_ASSERT_IMP(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("qpht assertion failed");
// next-cycle implication
`define QPHT_ASSERT_NXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("qpht assertion failed");
`else
`define QPHT_ASSERT_IMP(lbl, ck, rs, ante, cons)
`define QPHT_ASSERT_NXT(lbl, ck, rs, ante, cons)
`endif

`endif

// ===== design/qpht_pkg.sv =====
`default_nettype none

package qpht_pkg;

  // table geometry (slot count is a power of two)
  localparam int TABLE_SLOTS   = 64;
  localparam int SLOT_W        = $clog2(TABLE_SLOTS);
  localparam int MAX_KEY_CHARS = 8;

  // field widths
  localparam int OP_W     = 2;
  localparam int KEY_W    = 64;
  localparam int LEN_W    = 4;
  localparam int AMT_W    = 32;
  localparam int STATUS_W = 3;
  localparam int IDX_W    = 6;
  localparam int CNT_W    = 32;
  localparam int CHAR_CNT_W = 4;

  // stream packing
  localparam int S_FIELDS_W = KEY_W + LEN_W + AMT_W;
  localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
  localparam int M_FIELDS_W = AMT_W + IDX_W + CNT_W;
  localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

  // stored entry: key, length, amount
  localparam int ENTRY_W = KEY_W + LEN_W + AMT_W;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_FIND   = 2'd1,
    OP_DELETE = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    RES_INSERTED  = 3'd0,
    RES_FOUND     = 3'd1,
    RES_NOT_FOUND = 3'd2,
    RES_DELETED   = 3'd3,
    RES_FULL      = 3'd4
  } res_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic hash_step;
    logic probe_start;
    logic probe_next;
    logic write_entry;
    logic tomb_entry;
    logic set_result;
    res_t res_code;
    logic present;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    op_t  op;
    logic hash_done;
    logic slot_used;
    logic slot_tomb;
    logic key_match;
    logic probe_last;
  } stat_t;

endpackage

`default_nettype wire

// ===== design/qpht_datapath.sv =====
`default_nettype none

module qpht_datapath (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire qpht_pkg::cmd_t                  cmd,
  output qpht_pkg::stat_t                      stat,
  input  wire logic [qpht_pkg::OP_W-1:0]       in_op,
  input  wire logic [qpht_pkg::KEY_W-1:0]      in_key,
  input  wire logic [qpht_pkg::LEN_W-1:0]      in_len,
  input  wire logic signed [qpht_pkg::AMT_W-1:0] in_amount,
  output logic [qpht_pkg::STATUS_W-1:0]        out_status,
  output logic signed [qpht_pkg::AMT_W-1:0]    out_amount,
  output logic [qpht_pkg::IDX_W-1:0]           out_slot,
  output logic [qpht_pkg::CNT_W-1:0]           out_count
);

  localparam int SW = qpht_pkg::SLOT_W;

  // latched request
  qpht_pkg::op_t                 op;
  logic [qpht_pkg::KEY_W-1:0]    key;
  logic [qpht_pkg::LEN_W-1:0]    len;
  logic [qpht_pkg::AMT_W-1:0]    amount;

  // hash and probe walk
  logic [SW-1:0]                     hash;
  logic [qpht_pkg::CHAR_CNT_W-1:0]   char_cnt;
  logic [SW-1:0]                     addr;
  logic [SW-1:0]                     delta;
  logic [SW-1:0]                     probe_cnt;

  // slot state flags, cleared by reset
  logic [qpht_pkg::TABLE_SLOTS-1:0]  used_vec;
  logic [qpht_pkg::TABLE_SLOTS-1:0]  tomb_vec;

  // entry memory
  logic [qpht_pkg::ENTRY_W-1:0]      mem [qpht_pkg::TABLE_SLOTS];
  logic [qpht_pkg::ENTRY_W-1:0]      rd_entry;

  logic [qpht_pkg::CNT_W-1:0]        insert_cnt;
  qpht_pkg::res_t                    res_code;
  logic [qpht_pkg::AMT_W-1:0]        res_amount;
  logic [SW-1:0]                     res_slot;

  logic [qpht_pkg::LEN_W-1:0]        len_sat;
  logic [qpht_pkg::KEY_W-1:0]        key_masked;
  logic [7:0]                        cur_byte;
  logic [SW-1:0]                     hash_next;
  logic [qpht_pkg::KEY_W-1:0]        rd_key;
  logic [qpht_pkg::LEN_W-1:0]        rd_len;
  logic [qpht_pkg::AMT_W-1:0]        rd_amount;

  // saturate length and clear bytes past it
  always_comb begin
    len_sat = (in_len > qpht_pkg::LEN_W'(qpht_pkg::MAX_KEY_CHARS)) ?
              qpht_pkg::LEN_W'(qpht_pkg::MAX_KEY_CHARS) : in_len;
    for (int b = 0; b < 8; b++) begin
      key_masked[b*8 +: 8] = (qpht_pkg::LEN_W'(b) < len_sat) ? in_key[b*8 +: 8] : 8'd0;
    end
  end

  // one key byte per step: h = 37*h + byte, low slot bits only
  assign cur_byte  = key[{char_cnt[2:0], 3'b000} +: 8];
  assign hash_next = (hash << 5) + (hash << 2) + hash + SW'(cur_byte);

  assign {rd_amount, rd_len, rd_key} = rd_entry;

  // status toward the controller
  always_comb begin
    stat.op         = op;
    stat.hash_done  = (char_cnt == qpht_pkg::CHAR_CNT_W'(len));
    stat.slot_used  = used_vec[addr];
    stat.slot_tomb  = tomb_vec[addr];
    stat.key_match  = (rd_len == len) && (rd_key == key);
    stat.probe_last = (probe_cnt == SW'(qpht_pkg::TABLE_SLOTS - 1));
  end

  // request, hash and probe registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op       <= qpht_pkg::op_t'(in_op);
      key      <= key_masked;
      len      <= len_sat;
      amount   <= in_amount;
      hash     <= '0;
      char_cnt <= '0;
    end else if (cmd.hash_step) begin
      hash     <= hash_next;
      char_cnt <= char_cnt + 1'b1;
    end
    if (cmd.probe_start) begin
      addr      <= hash;
      delta     <= SW'(1);
      probe_cnt <= '0;
    end else if (cmd.probe_next) begin
      addr      <= addr + delta;
      delta     <= delta + SW'(2);
      probe_cnt <= probe_cnt + 1'b1;
    end
  end

  // entry memory, registered read at the probe address
  always_ff @(posedge clk) begin
    if (cmd.write_entry) begin
      mem[addr] <= {amount, len, key};
    end
    rd_entry <= mem[addr];
  end

  // slot flags and insert counter
  always_ff @(posedge clk) begin
    if (rst) begin
      used_vec   <= '0;
      tomb_vec   <= '0;
      insert_cnt <= '0;
    end else begin
      if (cmd.write_entry) begin
        used_vec[addr] <= 1'b1;
        tomb_vec[addr] <= 1'b0;
        insert_cnt     <= insert_cnt + 1'b1;
      end else if (cmd.tomb_entry) begin
        used_vec[addr] <= 1'b0;
        tomb_vec[addr] <= 1'b1;
      end
    end
  end

  // result capture
  always_ff @(posedge clk) begin
    if (cmd.set_result) begin
      res_code <= cmd.res_code;
      case (cmd.res_code)
        qpht_pkg::RES_INSERTED, qpht_pkg::RES_DELETED: begin
          res_slot   <= addr;
          res_amount <= '0;
        end
        qpht_pkg::RES_FOUND: begin
          res_slot   <= addr;
          res_amount <= rd_amount;
        end
        default: begin
          res_slot   <= '0;
          res_amount <= '0;
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.present) begin
      out_status <= res_code;
      out_amount <= res_amount;
      out_slot   <= qpht_pkg::IDX_W'(res_slot);
      out_count  <= insert_cnt;
    end
  end

endmodule

`default_nettype wire

// ===== design/qpht_ctrl.sv =====
`default_nettype none

`include "quadratic_probe_hash_table_core_macros.svh"

module qpht_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            s_axis_tvalid,
  output logic                 s_axis_tready,
  output logic                 m_axis_tvalid,
  input  wire logic            m_axis_tready,
  input  wire qpht_pkg::stat_t stat,
  output qpht_pkg::cmd_t       cmd
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_HASH  = 5'b00010,
    S_PROBE = 5'b00100,
    S_CHECK = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;
  logic   m_axis_tvalid_next;

  assign s_axis_tready = (state == S_IDLE);

  // sequencer
  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          cmd.load   = 1'b1;
          state_next = S_HASH;
        end
      end
      S_HASH: begin
        if (!stat.hash_done) begin
          cmd.hash_step = 1'b1;
        end else if (stat.op == qpht_pkg::OP_NONE) begin
          cmd.set_result = 1'b1;
          cmd.res_code   = qpht_pkg::RES_NOT_FOUND;
          state_next     = S_DONE;
        end else begin
          cmd.probe_start = 1'b1;
          state_next      = S_PROBE;
        end
      end
      S_PROBE: begin
        if (stat.op == qpht_pkg::OP_INSERT) begin
          if (!stat.slot_used) begin
            cmd.write_entry = 1'b1;
            cmd.set_result  = 1'b1;
            cmd.res_code    = qpht_pkg::RES_INSERTED;
            state_next      = S_DONE;
          end else if (stat.probe_last) begin
            cmd.set_result = 1'b1;
            cmd.res_code   = qpht_pkg::RES_FULL;
            state_next     = S_DONE;
          end else begin
            cmd.probe_next = 1'b1;
          end
        end else if (stat.slot_used) begin
          state_next = S_CHECK;
        end else if (!stat.slot_tomb || stat.probe_last) begin
          // never-used slot or probe limit ends the search
          cmd.set_result = 1'b1;
          cmd.res_code   = qpht_pkg::RES_NOT_FOUND;
          state_next     = S_DONE;
        end else begin
          cmd.probe_next = 1'b1;
        end
      end
      S_CHECK: begin
        if (stat.key_match) begin
          cmd.set_result = 1'b1;
          if (stat.op == qpht_pkg::OP_FIND) begin
            cmd.res_code = qpht_pkg::RES_FOUND;
          end else begin
            cmd.tomb_entry = 1'b1;
            cmd.res_code   = qpht_pkg::RES_DELETED;
          end
          state_next = S_DONE;
        end else if (stat.probe_last) begin
          cmd.set_result = 1'b1;
          cmd.res_code   = qpht_pkg::RES_NOT_FOUND;
          state_next     = S_DONE;
        end else begin
          cmd.probe_next = 1'b1;
          state_next     = S_PROBE;
        end
      end
      S_DONE: begin
        if (!m_axis_tvalid || m_axis_tready) begin
          cmd.present = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // output beat valid
  always_comb begin
    if (cmd.present) begin
      m_axis_tvalid_next = 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid_next = 1'b0;
    end else begin
      m_axis_tvalid_next = m_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      m_axis_tvalid <= 1'b0;
    end else begin
      state         <= state_next;
      m_axis_tvalid <= m_axis_tvalid_next;
    end
  end

  // a new result never overwrites one still waiting
  `QPHT_ASSERT_IMP(a_present_free, clk, rst, cmd.present, !m_axis_tvalid || m_axis_tready)
  // an entry is never written and tombstoned in the same cycle
  `QPHT_ASSERT_IMP(a_write_xor_tomb, clk, rst, cmd.write_entry, !cmd.tomb_entry)
  // an accepted beat starts the hash
  `QPHT_ASSERT_NXT(a_accept_hash, clk, rst, s_axis_tvalid && s_axis_tready, state == S_HASH)
  // key compare only follows a probe of an occupied slot
  `QPHT_ASSERT_IMP(a_check_after_probe, clk, rst, state == S_CHECK,
                   $past(state) == S_PROBE && $past(stat.slot_used))

endmodule

`default_nettype wire

// ===== design/quadratic_probe_hash_table_core.sv =====
// sequence: the input beat is loaded, hashed one key byte per step over the saturated key
//   length, then probed; an occupied slot's key is compared after the registered read of
//   the entry memory; the result is registered and then presented as the result beat
// throughput: one item at a time; the next beat is taken the cycle after the result is queued
// reset: slot flags and insert count clear in the reset cycle, no clearing pass
`default_nettype none

module quadratic_probe_hash_table_core (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  // key_bytes[63:0], key_length[67:64], amount[99:68], zero fill
  input  wire logic [qpht_pkg::S_TDATA_W-1:0]    s_axis_tdata,
  // opcode[1:0]
  input  wire logic [qpht_pkg::OP_W-1:0]         s_axis_tuser,
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // found_amount[31:0], slot_index[37:32], insert_count[69:38], zero fill
  output logic [qpht_pkg::M_TDATA_W-1:0]         m_axis_tdata,
  // status[2:0]
  output logic [qpht_pkg::STATUS_W-1:0]          m_axis_tuser
);

  localparam int KW = qpht_pkg::KEY_W;
  localparam int LW = qpht_pkg::LEN_W;
  localparam int AW = qpht_pkg::AMT_W;

  qpht_pkg::cmd_t  cmd;
  qpht_pkg::stat_t stat;

  logic signed [AW-1:0]              out_amount;
  logic [qpht_pkg::IDX_W-1:0]        out_slot;
  logic [qpht_pkg::CNT_W-1:0]        out_count;

  qpht_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .stat          (stat),
    .cmd           (cmd)
  );

  qpht_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .in_op      (s_axis_tuser),
    .in_key     (s_axis_tdata[KW-1:0]),
    .in_len     (s_axis_tdata[KW +: LW]),
    .in_amount  (s_axis_tdata[KW+LW +: AW]),
    .out_status (m_axis_tuser),
    .out_amount (out_amount),
    .out_slot   (out_slot),
    .out_count  (out_count)
  );

  // result beat packing
  assign m_axis_tdata = {{(qpht_pkg::M_TDATA_W - qpht_pkg::M_FIELDS_W){1'b0}},
                         out_count, out_slot, out_amount};

endmodule

`default_nettype wire
